/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checksum core modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AST_IMP(label, clk, rst_n, ante, cons, msg)
`define AST_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/core/uic_pkg.sv */
// ----------------------------------------------------------------------------
// uic_pkg
// Shared types, codes and helpers for the UDP/IPv6 checksum core.
// ----------------------------------------------------------------------------
`default_nettype none

package uic_pkg;

    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_LENGTH  = 2'd1;
    localparam logic [1:0] CMD_PAYLOAD = 2'd2;

    localparam logic [15:0] UDP_PROTO = 16'h0011;
    localparam logic [15:0] WORD_ONES = 16'hFFFF;

    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified item: the word to add and the end-of-packet mark.
    typedef struct packed {
        logic [15:0] addend;
        logic        last;
    } t_op;

    // End-around-carry fold of a sum of up to four 16-bit terms.
    function automatic logic [15:0] oc_fold(input logic [17:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/uic_front.sv */
// ----------------------------------------------------------------------------
// uic_front
// Takes input items, pairs payload bytes and reduces each item to one addend.
// ----------------------------------------------------------------------------
`default_nettype none

module uic_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [1:0]     i_cmd,
    input  wire logic [15:0]    i_data,
    input  wire logic           i_last,
    input  wire logic           i_full,
    output logic                o_ready,
    output logic                o_push,
    output uic_pkg::t_op        o_op
);

    logic [7:0]  r_held_byte, n_held_byte;
    logic        r_pending, n_pending;
    logic [15:0] w_a, w_b, w_pad;
    logic [17:0] raw;

    assign o_ready = !i_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        w_a         = '0;
        w_b         = '0;
        w_pad       = '0;
        n_held_byte = r_held_byte;
        n_pending   = r_pending;
        unique case (i_cmd)
            uic_pkg::CMD_HEADER: begin
                w_a = i_data;
            end
            uic_pkg::CMD_LENGTH: begin
                w_a = i_data;
                w_b = i_data;
            end
            uic_pkg::CMD_PAYLOAD: begin
                if (r_pending) begin
                    w_a         = {r_held_byte, i_data[7:0]};
                    n_held_byte = '0;
                    n_pending   = 1'b0;
                end else begin
                    n_held_byte = i_data[7:0];
                    n_pending   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // odd trailing byte is padded with a zero low byte
        if (i_last) begin
            if (n_pending) begin
                w_pad = {n_held_byte, 8'h00};
            end
            n_held_byte = '0;
            n_pending   = 1'b0;
        end
    end

    assign raw         = {2'b00, w_a} + {2'b00, w_b} + {2'b00, w_pad};
    assign o_op.addend = uic_pkg::oc_fold(raw);
    assign o_op.last   = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte <= '0;
            r_pending   <= 1'b0;
        end else if (o_push) begin
            r_held_byte <= n_held_byte;
            r_pending   <= n_pending;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/uic_fifo.sv */
// ----------------------------------------------------------------------------
// uic_fifo
// Short queue of classified items between the front and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module uic_fifo #(
    parameter int unsigned DEPTH = uic_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire uic_pkg::t_op   i_op,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_head_valid,
    output uic_pkg::t_op        o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    uic_pkg::t_op r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `AST_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "queue push while full")
    `AST_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_head_valid, "queue pop while empty")

endmodule

`default_nettype wire

/* rtl/core/uic_back.sv */
// ----------------------------------------------------------------------------
// uic_back
// Accumulates addends with end-around carry and finishes the checksum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module uic_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire uic_pkg::t_op   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [15:0]         o_checksum
);

    logic [15:0] r_sum;
    logic        r_out_valid;
    logic [15:0] r_checksum;
    logic [15:0] proto;
    logic [17:0] raw;
    logic [15:0] folded;
    logic [15:0] cpl;

    // a finishing item waits only while an unread checksum blocks the output
    assign o_pop = i_head_valid && (!i_head.last || !r_out_valid || i_ready);

    assign proto  = i_head.last ? uic_pkg::UDP_PROTO : 16'h0000;
    assign raw    = {2'b00, r_sum} + {2'b00, i_head.addend} + {2'b00, proto};
    assign folded = uic_pkg::oc_fold(raw);
    assign cpl    = (~folded == 16'h0000) ? uic_pkg::WORD_ONES : ~folded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sum <= i_head.last ? 16'h0000 : folded;
            end
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_checksum <= cpl;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_checksum;

    `AST_NXT(a_last_sets_out, i_clk, i_rst_n, o_pop && i_head.last, r_out_valid,
        "finished packet gave no checksum")
    `AST_IMP(a_out_from_last, i_clk, i_rst_n, $rose(r_out_valid),
        $past(o_pop) && $past(i_head.last), "checksum without finishing item")

endmodule

`default_nettype wire

/* rtl/core/udp_ipv6_checksum_core.sv */
// ----------------------------------------------------------------------------
// udp_ipv6_checksum_core
// UDP over IPv6 checksum: pseudo-header, header and payload items in, one
// checksum out per packet.
// ----------------------------------------------------------------------------
//  channel   direction  tdata           tuser          tlast
//  s (item)  in         [15:0] data_in  [1:0] command  last
//  m (sum)   out        [15:0] checksum  -              -
//
//  One item per clock while the queue has room; the front pairs bytes and
//  reduces each item to one addend, the back adds it into the running sum.
//  The checksum is registered: a last item is written into the queue when
//  taken, and the output register loads when that item leaves the queue.
//  Synchronous active-low reset clears byte pairing, running sum and queue.
//  Items keep flowing while a checksum waits; a finishing item stalls in the
//  queue only until the previous checksum is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_ipv6_checksum_core #(
    parameter int unsigned QUEUE_DEPTH = uic_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [15:0]    i_s_tdata,   // [15:0] data_in
    input  wire logic [1:0]     i_s_tuser,   // [1:0] command
    input  wire logic           i_s_tlast,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [15:0]         o_m_tdata    // [15:0] checksum
);

    uic_pkg::t_op push_op;
    uic_pkg::t_op head_op;
    logic push, pop, full, head_valid;

    uic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_cmd   (i_s_tuser),
        .i_data  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_op    (push_op)
    );

    uic_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_op         (push_op),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head_op)
    );

    uic_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_op),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_checksum   (o_m_tdata)
    );

endmodule

`default_nettype wire

/* dv/tb_udp_ipv6_checksum_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_udp_ipv6_checksum_core
// Self-checking bench for the UDP/IPv6 checksum core. Directed corner packets,
// then random well-formed UDP packets mixed with junk sequences, under random
// gaps and output stalls, plus a long output hold-off that fills the core.
// Each checksum is predicted on item acceptance and compared in order.
// ----------------------------------------------------------------------------
module tb_udp_ipv6_checksum_core;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_WAIT = 13;
    localparam int         REPORT_MAX = 10;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] word;
    } t_pkt_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic [1:0]  s_cmd = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_data;

    // predictor state
    logic [15:0] sum_acc = '0;
    logic [7:0]  held_hi = '0;
    logic        hi_pending = 1'b0;
    logic [15:0] exp_sums[$];

    bit idle_on = 1'b1;
    int rx_block_left = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int items_sent = 0;
    int packets_sent = 0;
    int sums_checked = 0;
    int max_rx_backlog = 0;

    always #10 i_clk = ~i_clk;

    udp_ipv6_checksum_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),     // [15:0] data_in
        .i_s_tuser  (s_cmd),      // [1:0] command
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)      // [15:0] checksum
    );

    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
    endfunction

    // Advance the checksum state by one accepted item.
    task automatic predict_item(logic [1:0] cmd, logic [15:0] word, logic last);
        logic [15:0] s;
        logic [15:0] c;
        case (cmd)
            uic_pkg::CMD_HEADER: begin
                sum_acc = ones_add(sum_acc, word);
            end
            uic_pkg::CMD_LENGTH: begin
                sum_acc = ones_add(ones_add(sum_acc, word), word);
            end
            uic_pkg::CMD_PAYLOAD: begin
                if (hi_pending) begin
                    sum_acc = ones_add(sum_acc, {held_hi, word[7:0]});
                    held_hi = '0;
                    hi_pending = 1'b0;
                end else begin
                    held_hi = word[7:0];
                    hi_pending = 1'b1;
                end
            end
            default: ;
        endcase
        if (last) begin
            s = sum_acc;
            if (hi_pending)
                s = ones_add(s, {held_hi, 8'h00});
            s = ones_add(s, uic_pkg::UDP_PROTO);
            c = ~s;
            exp_sums.push_back((c == 16'h0000) ? uic_pkg::WORD_ONES : c);
            sum_acc = '0;
            held_hi = '0;
            hi_pending = 1'b0;
        end
    endtask

    task automatic send_item(logic [1:0] cmd, logic [15:0] word, logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_data  <= word;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        predict_item(cmd, word, last);
        items_sent++;
        if (last)
            packets_sent++;
    endtask

    // Last flag goes on the final item of the queue.
    task automatic send_packet(t_pkt_item pkt[$]);
        foreach (pkt[i])
            send_item(pkt[i].cmd, pkt[i].word, i == pkt.size() - 1);
    endtask

    // Sender pause: nothing offered until every checksum has come back.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_sums.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void report_mismatch(string what, logic [15:0] exp_v,
                                            logic [15:0] act_v);
        if (err_cnt < REPORT_MAX)
            $display("%0t: %s: expected %04h, got %04h", $realtime, what, exp_v, act_v);
        err_cnt++;
    endfunction

    task automatic test_directed();
        t_pkt_item pkt[$];
        // empty packet: unused command carrying last
        pkt = '{'{CMD_UNUSED, 16'h0000}};
        send_packet(pkt);
        // all-ones header word folds back to the empty result
        pkt = '{'{uic_pkg::CMD_HEADER, 16'hFFFF}};
        send_packet(pkt);
        // sum lands on all ones: zero result sent as all ones; then an all-ones length word counted twice
        pkt = '{'{uic_pkg::CMD_HEADER, 16'hFFEE}};
        send_packet(pkt);
        pkt = '{'{uic_pkg::CMD_LENGTH, 16'hFFFF}, '{uic_pkg::CMD_HEADER, 16'h0000}};
        send_packet(pkt);
        // upper payload bits ignored, odd byte on last payload item
        pkt = '{'{uic_pkg::CMD_PAYLOAD, 16'hAB12}, '{uic_pkg::CMD_PAYLOAD, 16'hCD34},
                '{uic_pkg::CMD_PAYLOAD, 16'hFFEF}};
        send_packet(pkt);
        // header and length words land between paired bytes; odd byte padded
        // on a non-payload last
        pkt = '{'{uic_pkg::CMD_PAYLOAD, 16'h00FF}, '{uic_pkg::CMD_HEADER, 16'h1234},
                '{uic_pkg::CMD_LENGTH, 16'h0008}, '{uic_pkg::CMD_PAYLOAD, 16'h0080},
                '{uic_pkg::CMD_PAYLOAD, 16'h0001}, '{CMD_UNUSED, 16'hFFFF}};
        send_packet(pkt);
        pkt = '{'{uic_pkg::CMD_PAYLOAD, 16'h0077}, '{uic_pkg::CMD_HEADER, 16'h0000}};
        send_packet(pkt);
        // unused command must not disturb byte pairing
        pkt = '{'{CMD_UNUSED, 16'hFFFF}, '{uic_pkg::CMD_PAYLOAD, 16'hFF00},
                '{CMD_UNUSED, 16'h5555}, '{uic_pkg::CMD_PAYLOAD, 16'hFFFF}};
        send_packet(pkt);
    endtask

    // Well-formed UDP packet: addresses, length (sometimes random), ports, payload; sometimes
    // shuffled since the core accepts any order.
    task automatic build_udp_packet(ref t_pkt_item pkt[$]);
        int n_pay;
        int j;
        t_pkt_item tmp;
        pkt.delete();
        n_pay = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(0, 9);
        for (int i = 0; i < 16; i++)
            pkt.push_back('{uic_pkg::CMD_HEADER, 16'($urandom_range(0, 65535))});
        pkt.push_back('{uic_pkg::CMD_LENGTH, ($urandom_range(0, 5) == 0) ?
                        16'($urandom_range(0, 65535)) : 16'(8 + n_pay)});
        pkt.push_back('{uic_pkg::CMD_HEADER, 16'($urandom_range(0, 65535))});
        pkt.push_back('{uic_pkg::CMD_HEADER, 16'($urandom_range(0, 65535))});
        for (int i = 0; i < n_pay; i++)
            pkt.push_back('{uic_pkg::CMD_PAYLOAD, 16'($urandom_range(0, 65535))});
        if ($urandom_range(0, 3) == 0) begin
            for (int i = pkt.size() - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = pkt[i];
                pkt[i] = pkt[j];
                pkt[j] = tmp;
            end
        end
    endtask

    task automatic build_junk_packet(ref t_pkt_item pkt[$]);
        int n;
        pkt.delete();
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            pkt.push_back('{2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535))});
    endtask

    task automatic test_random_traffic(int n_items);
        t_pkt_item pkt[$];
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            // alternate stretches with and without idling
            if ($urandom_range(0, 5) == 0)
                idle_on = ~idle_on;
            if ($urandom_range(0, 9) < 7)
                build_udp_packet(pkt);
            else
                build_junk_packet(pkt);
            send_packet(pkt);
        end
        idle_on = 1'b1;
    endtask

    // Output held off for a long stretch while short packets keep coming,
    // so the core's queue fills and it stalls the input.
    task automatic test_backpressure();
        t_pkt_item pkt[$];
        idle_on = 1'b0;
        rx_block_left = 300;
        for (int k = 0; k < 30; k++) begin
            build_junk_packet(pkt);
            while (pkt.size() > 2)
                void'(pkt.pop_back());
            send_packet(pkt);
        end
        idle_on = 1'b1;
    endtask

    // Output ready: random stall after each checksum, plus the long hold-off.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready)
                stall = draw_wait();
            else if (stall > 0)
                stall--;
            if (rx_block_left > 0) begin
                rx_block_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= i_rst_n && (stall == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (exp_sums.size() == 0) begin
                report_mismatch("checksum with none pending", 16'h0000, m_data);
            end else begin
                if (m_data !== exp_sums[0])
                    report_mismatch("checksum", exp_sums[0], m_data);
                void'(exp_sums.pop_front());
            end
            sums_checked++;
        end
        if (exp_sums.size() > max_rx_backlog)
            max_rx_backlog = exp_sums.size();
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d checksums outstanding",
                     cycle_cnt, exp_sums.size());
            $display("udp_ipv6_checksum_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_results_drained();
        test_random_traffic(450);
        test_backpressure();
        wait_results_drained();
        test_random_traffic(420);
        wait_results_drained();
        repeat (8) @(posedge i_clk);

        if (exp_sums.size() != 0)
            err_cnt++;
        $display("Sent %0d items in %0d packets, checked %0d checksums",
                 items_sent, packets_sent, sums_checked);
        $display("Peak outstanding checksums %0d, mismatches %0d",
                 max_rx_backlog, err_cnt);
        if (err_cnt == 0) begin
            $display("udp_ipv6_checksum_core test passed");
        end else begin
            $display("udp_ipv6_checksum_core test failed");
        end
        $finish;
    end

endmodule
